// ===== rtl/psve_pkg.sv =====
// Shared types and constants for the pitch slide / vibrato engine.
// Holds the per-channel state word, the divider handshake and the op codes.
// No dependencies.
package psve_pkg;

	localparam int CHANNELS = 4;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam logic [1:0]  NO_VIB_CHANNEL = 2'd3;
	localparam logic [10:0] FREQ_MASK      = 11'h7FF;
	localparam logic [7:0]  BYTE_MASK      = 8'hFF;

	typedef enum logic {
		OP_NOTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef struct packed {
		logic [15:0] slide_current;
		logic [10:0] target_freq;
		logic        slide_on;
		logic        slide_down;
		logic [7:0]  step_whole;
		logic [7:0]  step_fraction;
		logic [7:0]  fraction_accum;
		logic [10:0] vibrato_base;
		logic [7:0]  vibrato_wait_left;
		logic [7:0]  vibrato_speed;
		logic [7:0]  vibrato_count;
		logic        vibrato_phase;
		logic [7:0]  vibrato_amount;
	} chan_state_t;

	typedef struct packed {
		logic       start;
		logic [7:0] dividend;
		logic [7:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] quotient;
		logic [7:0] remainder;
	} div_rsp_t;

	function automatic chan_state_t chan_reset_state();
		chan_state_t s;
		s                   = '0;
		s.vibrato_speed     = 8'd1;
		s.vibrato_count     = 8'd1;
		return s;
	endfunction

endpackage

// ===== rtl/pitch_slide_vibrato_engine_core.sv =====
// Pitch slide and vibrato engine: four tone channels, per-channel state in one memory.
// Each request is a read-modify-write through the state memory. A tick runs the slide,
// vibrato and write-back states; a note start with a slide runs the 8-step slide-step
// divider before write-back. A new request is taken only when idle, after the last report.
// Reset (arst_n low, async): control idles, output word drops, every channel reads
// as its reset state until first written.
module pitch_slide_vibrato_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [1:0]  channel,
	input  logic        muted,
	input  logic [10:0] note_freq,
	input  logic [10:0] slide_goal,
	input  logic [7:0]  slide_length,
	input  logic [7:0]  vibrato_wait,
	input  logic [7:0]  vibrato_speed,
	input  logic [7:0]  vibrato_amount,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_channel,
	output logic        freq_write,
	output logic [10:0] frequency
);
	import psve_pkg::*;

	// Sequencer: read the channel entry, apply slide (or load a note), run the divider
	// for a sliding note or apply vibrato for a tick, then write back and report.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLIDE,
		ST_DIV,
		ST_VIB,
		ST_WB
	} state_t;

	state_t      state_q;
	logic        out_valid_q;
	logic [1:0]  out_channel_q;
	logic        freq_write_q;
	logic [10:0] frequency_q;

	// Captured input word
	op_t         op_q;
	logic [1:0]  ch_q;
	logic        muted_q;
	logic        ch_ok_q;
	logic [10:0] freq_q;
	logic [10:0] goal_q;
	logic [7:0]  len_q;
	logic [7:0]  wait_q;
	logic [7:0]  speed_q;
	logic [7:0]  amount_q;

	// Working copy of the channel entry and the pending write
	chan_state_t ent_q;
	logic [7:0]  dh_q;
	logic        wrote_q;
	logic [10:0] wf_q;

	logic        accept;
	logic        ch_ok_in;
	logic        out_free;
	logic [CH_W-1:0] rd_addr;
	logic [CH_W-1:0] ch_idx;
	chan_state_t mem_rd;
	logic        mem_wr_en;
	div_req_t    div_req;
	div_rsp_t    div_rsp;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign ch_ok_in = (32'(channel) < CHANNELS);
	assign out_free = !out_valid_q || out_ready;
	assign rd_addr  = CH_W'({{CH_W{1'b0}}, channel});
	assign ch_idx   = CH_W'({{CH_W{1'b0}}, ch_q});
	assign mem_wr_en = (state_q == ST_WB) && out_free && ch_ok_q;

	psve_state_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && ch_ok_in),
		.rd_addr (rd_addr),
		.rd_data (mem_rd),
		.wr_en   (mem_wr_en),
		.wr_addr (ch_idx),
		.wr_data (ent_q)
	);

	// ---------------------------------------------------------------
	// Note start: build the fresh entry and the step's high byte.
	// ---------------------------------------------------------------
	chan_state_t note_ent;
	logic        note_active;
	logic        note_down;
	logic [10:0] diff_dn;
	logic        borrow;
	logic [7:0]  cur_hi_adj;
	logic [7:0]  dh_note;
	logic [7:0]  dl_note;

	assign note_active = (freq_q != '0) && (goal_q != '0) && (len_q != '0) &&
	                     (freq_q != goal_q);
	assign note_down   = (freq_q >= goal_q);
	assign diff_dn     = freq_q - goal_q;
	assign borrow      = (goal_q[7:0] < freq_q[7:0]);
	// Upward slide keeps the original borrow quirk: when the low bytes borrow, the high byte comes out two too large.
	assign cur_hi_adj  = {5'b0, freq_q[10:8]} - {7'b0, borrow};
	always_comb begin
		if (note_down) begin
			dh_note = {5'b0, diff_dn[10:8]};
			dl_note = diff_dn[7:0];
		end else begin
			dh_note = {5'b0, goal_q[10:8]} - cur_hi_adj;
			dl_note = (goal_q[7:0] - freq_q[7:0]) & BYTE_MASK;
		end
	end

	always_comb begin
		note_ent                   = '0;
		note_ent.vibrato_base      = freq_q;
		note_ent.vibrato_wait_left = wait_q;
		note_ent.vibrato_speed     = (speed_q != '0) ? speed_q : 8'd1;
		note_ent.vibrato_count     = (speed_q != '0) ? speed_q : 8'd1;
		note_ent.vibrato_phase     = 1'b0;
		note_ent.vibrato_amount    = amount_q;
		note_ent.slide_on          = note_active;
		note_ent.slide_down        = note_active && note_down;
		note_ent.slide_current     = {5'b0, freq_q};
		note_ent.target_freq       = goal_q;
	end

	assign div_req.start    = (state_q == ST_SLIDE) && (op_q == OP_NOTE) && note_active;
	assign div_req.dividend = dl_note;
	assign div_req.divisor  = len_q;

	psve_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---------------------------------------------------------------
	// Slide tick on the entry just read
	// ---------------------------------------------------------------
	chan_state_t slide_ent;
	logic        slide_wr;
	logic [10:0] slide_f;
	logic [8:0]  frac_sum;
	logic [8:0]  frac_dbl;
	logic [15:0] cur_up;
	logic [15:0] cur_dn;
	logic [15:0] cur_n;
	logic [15:0] tgt_ext;
	logic        slide_fin;

	assign frac_sum = {1'b0, mem_rd.step_fraction} + {1'b0, mem_rd.fraction_accum};
	assign frac_dbl = {mem_rd.step_fraction, 1'b0};
	assign cur_up   = mem_rd.slide_current + {8'b0, mem_rd.step_whole} + {15'b0, frac_sum[8]};
	assign cur_dn   = mem_rd.slide_current - {8'b0, mem_rd.step_whole} - {15'b0, frac_dbl[8]};
	assign tgt_ext  = {5'b0, mem_rd.target_freq};

	always_comb begin
		slide_ent = mem_rd;
		slide_wr  = 1'b0;
		slide_f   = '0;
		cur_n     = mem_rd.slide_current;
		slide_fin = 1'b0;
		if (mem_rd.slide_on) begin
			if (!mem_rd.slide_down) begin
				slide_ent.fraction_accum = frac_sum[7:0];
				cur_n     = cur_up;
				slide_fin = (cur_up > tgt_ext);
			end else begin
				// Downward slides double the fraction in place.
				slide_ent.step_fraction = frac_dbl[7:0];
				cur_n     = cur_dn;
				slide_fin = (cur_dn < tgt_ext);
			end
			if (slide_fin) begin
				slide_ent.slide_on = 1'b0;
				cur_n = tgt_ext;
			end
			slide_ent.slide_current = cur_n;
			slide_ent.vibrato_base  = cur_n[10:0] & FREQ_MASK;
			slide_wr = 1'b1;
			slide_f  = cur_n[10:0] & FREQ_MASK;
		end
	end

	// ---------------------------------------------------------------
	// Vibrato tick on the working entry
	// ---------------------------------------------------------------
	chan_state_t vib_ent;
	logic        vib_wr;
	logic [10:0] vib_f;
	logic [10:0] amt_ext;
	logic        vib_phase_n;

	assign amt_ext     = {3'b0, ent_q.vibrato_amount};
	assign vib_phase_n = !ent_q.vibrato_phase;

	always_comb begin
		vib_ent = ent_q;
		vib_wr  = 1'b0;
		vib_f   = '0;
		if ((ch_q != NO_VIB_CHANNEL) && !ent_q.slide_on &&
		    (ent_q.vibrato_amount != '0) && (ent_q.vibrato_base != '0)) begin
			if (ent_q.vibrato_wait_left != '0) begin
				vib_ent.vibrato_wait_left = ent_q.vibrato_wait_left - 8'd1;
			end else if (ent_q.vibrato_count > 8'd1) begin
				vib_ent.vibrato_count = ent_q.vibrato_count - 8'd1;
			end else begin
				vib_ent.vibrato_phase = vib_phase_n;
				vib_ent.vibrato_count = ent_q.vibrato_speed;
				vib_wr = 1'b1;
				vib_f  = vib_phase_n ? (ent_q.vibrato_base - amt_ext)
				                     : (ent_q.vibrato_base + amt_ext);
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequencer and output word
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			out_valid_q   <= 1'b0;
			out_channel_q <= '0;
			freq_write_q  <= 1'b0;
			frequency_q   <= '0;
		end else begin
			// Drop a taken word unless a new one replaces it this cycle.
			if (out_valid_q && out_ready && !((state_q == ST_WB) && out_free)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ch_ok_in ? ST_SLIDE : ST_WB;
					end
				end
				ST_SLIDE: begin
					if (op_q == OP_TICK) begin
						state_q <= ST_VIB;
					end else if (note_active) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_WB;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_WB;
					end
				end
				ST_VIB: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					// Hold until the output register frees up, then report.
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_channel_q <= ch_q;
						freq_write_q  <= wrote_q && !muted_q;
						frequency_q   <= (wrote_q && !muted_q) ? wf_q : '0;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op_t'(operation);
			ch_q     <= channel;
			muted_q  <= muted;
			ch_ok_q  <= ch_ok_in;
			freq_q   <= note_freq;
			goal_q   <= slide_goal;
			len_q    <= slide_length;
			wait_q   <= vibrato_wait;
			speed_q  <= vibrato_speed;
			amount_q <= vibrato_amount;
			wrote_q  <= 1'b0;
			wf_q     <= '0;
		end
		if (state_q == ST_SLIDE) begin
			if (op_q == OP_TICK) begin
				ent_q   <= slide_ent;
				wrote_q <= slide_wr;
				wf_q    <= slide_f;
			end else begin
				ent_q <= note_ent;
				dh_q  <= dh_note;
			end
		end
		if ((state_q == ST_DIV) && div_rsp.done) begin
			ent_q.step_whole     <= dh_q + div_rsp.quotient + 8'd1;
			ent_q.step_fraction  <= div_rsp.remainder;
			ent_q.fraction_accum <= div_rsp.remainder;
		end
		if (state_q == ST_VIB) begin
			ent_q <= vib_ent;
			if (vib_wr) begin
				wrote_q <= 1'b1;
				wf_q    <= vib_f & FREQ_MASK;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_channel_q;
	assign freq_write  = freq_write_q;
	assign frequency   = frequency_q;

endmodule

// ===== rtl/psve_div.sv =====
// Restoring divider for the slide step: 8-bit by 8-bit, one quotient bit per cycle.
// Depends on psve_pkg for the request and response structs.
module psve_div (
	input  logic               clk,
	input  logic               arst_n,
	input  psve_pkg::div_req_t req,
	output psve_pkg::div_rsp_t rsp
);
	import psve_pkg::*;

	logic       busy_q;
	logic       done_q;
	logic [2:0] cnt_q;
	logic [7:0] rem_q;
	logic [7:0] quo_q;
	logic [7:0] dvs_q;
	logic [8:0] trial;
	logic [8:0] diff;
	logic       ge;

	assign trial = {rem_q, quo_q[7]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[7:0] : trial[7:0];
			quo_q <= {quo_q[6:0], ge};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== rtl/psve_state_mem.sv =====
// Per-channel state memory: one write port, one registered read port.
// Valid bits make an unwritten entry read as the reset state. Depends on psve_pkg.
module psve_state_mem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [psve_pkg::CH_W-1:0]  rd_addr,
	output psve_pkg::chan_state_t      rd_data,
	input  logic                       wr_en,
	input  logic [psve_pkg::CH_W-1:0]  wr_addr,
	input  psve_pkg::chan_state_t      wr_data
);
	import psve_pkg::*;

	chan_state_t          mem [CHANNELS];
	logic [CHANNELS-1:0]  vld_q;
	chan_state_t          rd_data_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : chan_reset_state();

endmodule

// ===== rtl/psve_checker.sv =====
// Port-level checks for pitch_slide_vibrato_engine_core, attached by bind.
// Sees only the top-level ports; no package dependency.
module psve_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        operation,
	input logic [1:0]  channel,
	input logic        muted,
	input logic [10:0] note_freq,
	input logic [10:0] slide_goal,
	input logic [7:0]  slide_length,
	input logic [7:0]  vibrato_wait,
	input logic [7:0]  vibrato_speed,
	input logic [7:0]  vibrato_amount,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_channel,
	input logic        freq_write,
	input logic [10:0] frequency
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_channel) &&
		$stable(freq_write) && $stable(frequency))
		else $error("result word changed while stalled");

	// No write reported means a zero frequency.
	a_zero_freq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !freq_write |-> frequency == 11'd0)
		else $error("frequency nonzero without a write");

	// One word at a time: the block is busy right after taking a word.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after accept");

	// A new result only appears after a busy cycle.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work");

endmodule

bind pitch_slide_vibrato_engine_core psve_checker u_psve_checker (.*);
